// ----- rtl/core/chunk_overlong_truncation_walker_unit_assert.svh -----
// Assertion macros for the chunk walker; clocked on clk_i, off during reset.
`ifndef CHUNK_OVERLONG_TRUNCATION_WALKER_UNIT_ASSERT_SVH
`define CHUNK_OVERLONG_TRUNCATION_WALKER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define COTW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define COTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/cotw_pkg.sv -----
// Types and constants shared by the chunk walker modules.
package cotw_pkg;

  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned TagBytes    = 4;
  localparam int unsigned HdrCntW     = $clog2(HeaderBytes);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] kept_length;
    logic        was_cut;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } cotw_res_t;

endpackage

// ----- rtl/core/cotw_in_stage.sv -----
// Input register stage: holds one accepted byte until the walker takes it.
module cotw_in_stage import cotw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     advance_i,
  output logic     held_valid_o,
  output in_item_t held_item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;
  assign valid_d    = take || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_data_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_item_o  = item_q;

endmodule

// ----- rtl/core/cotw_walker.sv -----
// Walker state: byte position, header gather, body skip and cut tracking.
module cotw_walker import cotw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        step_i,
  input  in_item_t    item_i,
  output cotw_res_t   res_o
);

  logic [31:0]        total_q;
  logic [31:0]        pos_q, pos_d;
  logic [HdrCntW-1:0] hbs_q, hbs_d;
  logic [31:0]        sg_q, sg_d;
  logic [30:0]        skip_q, skip_d;
  logic               cut_q, cut_d;
  logic [31:0]        cutp_q, cutp_d;

  logic [31:0] sg_next;
  logic [1:0]  lane;
  logic        start_ok;
  logic [32:0] after;
  logic [32:0] remaining;

  assign lane     = 2'(hbs_q - HdrCntW'(TagBytes));
  assign start_ok = ({1'b0, pos_q} + 33'(HeaderBytes)) <= {1'b0, total_q};
  assign after    = {1'b0, pos_q} + 33'd1;
  assign remaining = (after <= {1'b0, total_q}) ? ({1'b0, total_q} - after) : 33'd0;

  always_comb begin
    sg_next = (hbs_q == '0) ? 32'd0 : sg_q;
    if (hbs_q >= HdrCntW'(TagBytes)) begin
      sg_next = sg_next | ({24'd0, item_i.data_byte} << {lane, 3'b000});
    end
  end

  always_comb begin
    pos_d  = pos_q + 32'd1;
    hbs_d  = hbs_q;
    sg_d   = sg_q;
    skip_d = skip_q;
    cut_d  = cut_q;
    cutp_d = cutp_q;
    if (!cut_q) begin
      if (skip_q != '0) begin
        skip_d = skip_q - 31'd1;
      end else if (hbs_q != '0 || start_ok) begin
        sg_d = sg_next;
        if (hbs_q == HdrCntW'(HeaderBytes - 1)) begin
          hbs_d = '0;
          // negative size means header only
          if (!sg_next[31]) begin
            if ({1'b0, sg_next} > remaining) begin
              cut_d  = 1'b1;
              cutp_d = pos_q - 32'(HeaderBytes - 1);
            end else begin
              skip_d = sg_next[30:0];
            end
          end
        end else begin
          hbs_d = hbs_q + HdrCntW'(1);
        end
      end
    end

    res_o.valid            = step_i && item_i.last_byte;
    res_o.item.kept_length = cut_d ? cutp_d : total_q;
    res_o.item.was_cut     = cut_d;

    // end of file: start the next file from scratch
    if (item_i.last_byte) begin
      pos_d  = '0;
      hbs_d  = '0;
      sg_d   = '0;
      skip_d = '0;
      cut_d  = 1'b0;
      cutp_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      pos_q   <= '0;
      hbs_q   <= '0;
      sg_q    <= '0;
      skip_q  <= '0;
      cut_q   <= 1'b0;
      cutp_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
      if (step_i) begin
        pos_q  <= pos_d;
        hbs_q  <= hbs_d;
        sg_q   <= sg_d;
        skip_q <= skip_d;
        cut_q  <= cut_d;
        cutp_q <= cutp_d;
      end
    end
  end

endmodule

// ----- rtl/core/cotw_out_stage.sv -----
// Result register: holds one result until the receiver takes it.
module cotw_out_stage import cotw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cotw_res_t res_i,
  output logic      can_take_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic      valid_q, valid_d;
  out_item_t item_q;

  assign can_take_o = !valid_q || out_ready_i;
  assign valid_d    = res_i.valid || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      item_q <= res_i.item;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = item_q;

endmodule

// ----- rtl/core/chunk_overlong_truncation_walker_unit.sv -----
// Chunk stream walker: one byte per transfer in, one length/cut result per file out.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one file byte per
// transfer plus a last-byte mark. Each section opens with an 8-byte header
// (4 tag bytes, 4-byte little-endian signed size); an overlong size cuts the
// file at that header. The output channel (out_valid_o/out_ready_i/out_data_o)
// carries one result per file, on its last byte: kept length and cut flag.
// cfg_we_i/cfg_wdata_i load the file's total length; write it while idle.
// A taken byte is held in the input register and walked combinationally out of
// it; a last byte's result is then registered in the output register and driven
// from there. The walker updates its counters once per walked byte.
// Throughput: one byte per cycle while no last byte waits on a full result slot.
// When the receiver stalls, the held result stays put, non-last bytes keep
// flowing, and a further last byte waits in the input register until the
// result register frees up.
// Reset clears the walk state, the total length and both valid flags.
`include "chunk_overlong_truncation_walker_unit_assert.svh"

module chunk_overlong_truncation_walker_unit import cotw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  logic      held_valid;
  in_item_t  held_item;
  logic      can_take;
  logic      advance;
  cotw_res_t res;

  // a last byte needs a free result slot; others always move on
  assign advance = held_valid && (!held_item.last_byte || can_take);

  cotw_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .advance_i    (advance),
    .held_valid_o (held_valid),
    .held_item_o  (held_item)
  );

  cotw_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .item_i      (held_item),
    .res_o       (res)
  );

  cotw_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .can_take_o  (can_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `COTW_ASSERT_NEXT(a_last_gives_result, advance && held_item.last_byte, out_valid_o,
                    "last byte walked but no result registered")
  `COTW_ASSERT_NOW(a_no_overwrite, out_valid_o && !out_ready_i && held_item.last_byte,
                   !advance, "pending result would be overwritten")
  `COTW_ASSERT_NOW(a_empty_is_ready, !held_valid, in_ready_o,
                   "empty input register refuses a transfer")

endmodule
